@@ rtl/core/agcr_pkg.sv @@
// ----------------------------------------------------------------------------
// agcr_pkg
// Shared types, constants and the polyphase coefficient ROM of the AGC
// resampler.
// ----------------------------------------------------------------------------
package agcr_pkg;

  localparam int COEF_WIDTH  = 18;
  localparam int COEF_FRAC   = COEF_WIDTH - 1;
  localparam int SAMPLE_W    = 16;
  localparam int IN_W        = 24;
  localparam int TARGET_W    = 15;
  localparam int RELEASE_W   = 24;
  localparam int PEAK_W      = 48;
  localparam int PHASE_W     = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int ROM_PHASES  = 4;
  localparam int ROM_TAPS    = 120;

  localparam logic [TARGET_W-1:0]  TARGET_RST  = 15'd8000;
  localparam logic [TARGET_W-1:0]  FLOOR_RST   = 15'd50;
  localparam logic [RELEASE_W-1:0] RELEASE_RST = 24'd16776378;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RELEASE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd2;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       due;
    logic [PHASE_W-1:0]         phase;
    logic                       block_end;
  } agcr_job_t;

  // Phases 0 and 1; phase 2 is phase 1 reversed, phase 3 is phase 0 reversed.
  localparam coef_t ROM_H0 [ROM_TAPS] = '{
    0, 0, -1, -1, 1, 4, 7, 3, -7, -17, -18, -3, 24, 43, 35, -6,
    -60, -85, -51, 36, 125, 144, 56, -103, -230, -215, -31, 227, 381, 286, -50, -431,
    -580, -329, 226, 739, 817, 306, -546, -1178, -1074, -153, 1080, 1782, 1317, -228,
    -1952, -2623, -1496, 1036, 3455, 3927, 1526, -2876, -6680, -6740, -1106, 9620,
    22163, 31877, 34888, 29960, 19107, 6602, -3066, -7219, -5964, -1708, 2382, 4069,
    2967, 340, -1947, -2611, -1573, 222, 1553, 1700, 788, -441, -1184, -1073, -329, 482,
    854, 638, 74, -429, -577, -347, 49, 336, 362, 164, -90, -236, -208, -62, 87, 149,
    107, 12, -65, -83, -47, 6, 40, 40, 17, -8, -20, -15, -4, 5, 6, 3, 0, -1, -1, 0
  };

  localparam coef_t ROM_H1 [ROM_TAPS] = '{
    0, 0, -1, -1, 2, 5, 6, 1, -10, -19, -16, 3, 30, 44, 27, -20,
    -70, -82, -33, 61, 139, 132, 20, -143, -242, -184, 32, 282, 383, 219, -152, -500,
    -556, -209, 375, 812, 742, 106, -748, -1234, -910, 157, 1339, 1786, 1009, -690,
    -2263, -2517, -951, 1727, 3816, 3597, 535, -4010, -7156, -5892, 1185, 12759,
    25039, 33362, 34375, 27660, 15946, 3771, -4666, -7348, -5057, -556, 3078, 4028,
    2381, -331, -2290, -2487, -1146, 639, 1710, 1549, 475, -697, -1237, -927, -109, 629,
    851, 514, -72, -505, -549, -252, 139, 368, 328, 99, -141, -245, -178, -20, 113, 147,
    85, -11, -76, -78, -34, 18, 43, 36, 10, -13, -20, -13, -1, 6, 6, 3, 0, -1, 0, 0
  };

  // Taps outside the stored ROM read as zero.
  function automatic coef_t coef_at(int unsigned phase, int unsigned tap);
    coef_t c;
    c = '0;
    if (phase < ROM_PHASES && tap < ROM_TAPS) begin
      if (phase == 0) begin
        c = ROM_H0[tap];
      end else if (phase == 1) begin
        c = ROM_H1[tap];
      end else if (phase == 2) begin
        c = ROM_H1[ROM_TAPS-1-tap];
      end else begin
        c = ROM_H0[ROM_TAPS-1-tap];
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/agc_polyphase_resampler.sv @@
// ----------------------------------------------------------------------------
// agc_polyphase_resampler
// Peak AGC followed by a 4/15 polyphase resampler with subblock marking.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i          | write only
//  in      | in_valid_i, in_stall_o, in_sample_i      | sample in
//  out     | out_valid_o, out_stall_i, out_sample_o,  | result out
//          | out_block_end_o                          |
//
// Front end: two 24x24 peak products and a 17-step divider per sample; no new
// sample is taken until its job is pushed. Back end: a sample that yields an
// output runs a serial MAC through the single history memory read port.
// A two-entry job queue lets the front run ahead while the MAC is busy.
// Reset clears control state; history entries read as zero until first
// written, tracked by a fill count.
module agc_polyphase_resampler import agcr_pkg::*; #(
  parameter int TAPS_PER_PHASE = 120,
  parameter int INTERP         = 4,
  parameter int DECIM          = 15,
  parameter int BLOCK_SIZE     = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [IN_W-1:0]     in_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] out_sample_o,
  output logic                       out_block_end_o
);

  logic [TARGET_W-1:0]  target_q, floor_q;
  logic [RELEASE_W-1:0] release_q;
  logic                 fr_valid, q_full, q_valid, bk_pop;
  agcr_job_t            fr_job, q_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= TARGET_RST;
      floor_q   <= FLOOR_RST;
      release_q <= RELEASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TARGET:  target_q  <= cfg_data_i[TARGET_W-1:0];
        CFG_FLOOR:   floor_q   <= cfg_data_i[TARGET_W-1:0];
        CFG_RELEASE: release_q <= cfg_data_i[RELEASE_W-1:0];
        default: ;
      endcase
    end
  end

  agcr_front #(
    .INTERP     (INTERP),
    .DECIM      (DECIM),
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .target_i    (target_q),
    .floor_i     (floor_q),
    .release_i   (release_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_sample_i (in_sample_i),
    .job_valid_o (fr_valid),
    .job_o       (fr_job),
    .job_full_i  (q_full)
  );

  agcr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_job_i   (fr_job),
    .full_o       (q_full),
    .pop_valid_o  (q_valid),
    .pop_job_o    (q_job),
    .pop_i        (bk_pop)
  );

  agcr_back #(
    .TAPS_PER_PHASE (TAPS_PER_PHASE)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (q_valid),
    .job_i           (q_job),
    .job_pop_o       (bk_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_sample_o    (out_sample_o),
    .out_block_end_o (out_block_end_o)
  );

`ifndef NO_ASSERTIONS
  a_pop_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_pop |-> q_valid) else $error("back end popped an empty queue");

  a_front_busy_when_pushing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_valid |-> in_stall_o) else $error("front end offers a job while idle");

  a_block_end_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_valid && fr_job.block_end) |-> fr_job.due)
    else $error("subblock end flagged on a job without output");
`endif

endmodule

@@ rtl/core/agcr_front.sv @@
// ----------------------------------------------------------------------------
// agcr_front
// Peak tracker, gain division and output scheduling for one input sample.
// ----------------------------------------------------------------------------
module agcr_front import agcr_pkg::*; #(
  parameter int INTERP     = 4,
  parameter int DECIM      = 15,
  parameter int BLOCK_SIZE = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [TARGET_W-1:0]   target_i,
  input  logic [TARGET_W-1:0]   floor_i,
  input  logic [RELEASE_W-1:0]  release_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [IN_W-1:0]       in_sample_i,
  output logic                  job_valid_o,
  output agcr_job_t             job_o,
  input  logic                  job_full_i
);

  localparam int OFF_W  = $clog2(INTERP + DECIM + 1);
  localparam int FILL_W = $clog2(BLOCK_SIZE + 1);
  localparam int NT_W   = IN_W + TARGET_W;
  localparam int REM_W  = NT_W + 24;
  localparam int DV_W   = PEAK_W + 16;
  localparam int QUO_W  = 17;

  typedef enum logic [6:0] {
    F_IDLE  = 7'b0000001,
    F_MULH  = 7'b0000010,
    F_MULL  = 7'b0000100,
    F_PEAK  = 7'b0001000,
    F_SETUP = 7'b0010000,
    F_DIV   = 7'b0100000,
    F_PUSH  = 7'b1000000
  } fstate_e;

  fstate_e               state_q, state_d;
  logic [IN_W-1:0]       mag_q;
  logic                  neg_q;
  logic [PEAK_W-1:0]     peak_q, peak_d;
  logic [PEAK_W-1:0]     prod_hi_q, prod_lo_q;
  logic [NT_W-1:0]       nt_q;
  logic [REM_W-1:0]      rem_q;
  logic [DV_W-1:0]       dv_q;
  logic [QUO_W-1:0]      quo_q;
  logic                  sat_q, zero_q;
  logic [4:0]            bit_q;
  logic [OFF_W-1:0]      off_q;
  logic [FILL_W-1:0]     fill_q, fill_inc;
  logic                  due_q;
  logic [PHASE_W-1:0]    phase_q;

  logic [IN_W-1:0]       mag_in;
  logic [PEAK_W-1:0]     decay, attack, floor_pk, pk;
  logic                  ge;
  logic [QUO_W-1:0]      qmag;
  logic                  push;

  assign mag_in   = in_sample_i[IN_W-1] ? (~in_sample_i + 1'b1) : in_sample_i;
  assign decay    = prod_hi_q + {24'd0, prod_lo_q[PEAK_W-1:24]};
  assign attack   = {mag_q, 24'd0};
  assign peak_d   = (attack > decay) ? attack : decay;
  assign floor_pk = {9'd0, floor_i, 24'd0};
  assign pk       = (peak_q < floor_pk) ? floor_pk : peak_q;
  assign ge       = {1'b0, rem_q} >= dv_q;
  assign fill_inc = fill_q + 1'b1;
  assign push     = (state_q == F_PUSH) && !job_full_i;

  always_comb begin
    if (zero_q) begin
      qmag = '0;
    end else if (neg_q) begin
      qmag = (sat_q || quo_q > 17'd32768) ? 17'd32768 : quo_q;
    end else begin
      qmag = (sat_q || quo_q > 17'd32767) ? 17'd32767 : quo_q;
    end
  end

  assign in_stall_o      = (state_q != F_IDLE);
  assign job_valid_o     = (state_q == F_PUSH);
  assign job_o.sample    = neg_q ? SAMPLE_W'(-qmag) : SAMPLE_W'(qmag);
  assign job_o.due       = due_q;
  assign job_o.phase     = phase_q;
  assign job_o.block_end = due_q && (fill_inc >= FILL_W'(BLOCK_SIZE));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (in_valid_i) state_d = F_MULH;
      F_MULH:  state_d = F_MULL;
      F_MULL:  state_d = F_PEAK;
      F_PEAK:  state_d = F_SETUP;
      F_SETUP: state_d = F_DIV;
      F_DIV:   if (bit_q == 5'd0) state_d = F_PUSH;
      F_PUSH:  if (!job_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      peak_q  <= {9'd0, TARGET_RST, 24'd0};
      off_q   <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_PEAK) peak_q <= peak_d;
      if (state_q == F_DIV && off_q < OFF_W'(INTERP)) off_q <= off_q + OFF_W'(DECIM);
      if (push) begin
        off_q <= off_q - OFF_W'(INTERP);
        if (due_q) fill_q <= job_o.block_end ? '0 : fill_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      F_IDLE: begin
        mag_q <= mag_in;
        neg_q <= in_sample_i[IN_W-1];
      end
      F_MULH: prod_hi_q <= PEAK_W'(peak_q[PEAK_W-1:24]) * PEAK_W'(release_i);
      F_MULL: prod_lo_q <= PEAK_W'(peak_q[23:0]) * PEAK_W'(release_i);
      F_PEAK: nt_q <= NT_W'(mag_q) * NT_W'(target_i);
      F_SETUP: begin
        rem_q   <= {nt_q, 24'd0};
        dv_q    <= {pk, 16'd0};
        zero_q  <= (pk == '0);
        sat_q   <= {2'b0, nt_q, 24'd0} >= {pk, 17'd0};
        bit_q   <= 5'd16;
        quo_q   <= '0;
        due_q   <= off_q < OFF_W'(INTERP);
        phase_q <= PHASE_W'(off_q);
      end
      F_DIV: begin
        if (ge) rem_q <= rem_q - REM_W'(dv_q);
        quo_q <= {quo_q[QUO_W-2:0], ge};
        dv_q  <= dv_q >> 1;
        bit_q <= bit_q - 5'd1;
      end
      F_PUSH: ;
      default: ;
    endcase
  end

endmodule

@@ rtl/core/agcr_queue.sv @@
// ----------------------------------------------------------------------------
// agcr_queue
// Short job queue between the AGC front end and the filter back end.
// ----------------------------------------------------------------------------
module agcr_queue import agcr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  input  agcr_job_t push_job_i,
  output logic      full_o,
  output logic      pop_valid_o,
  output agcr_job_t pop_job_o,
  input  logic      pop_i
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  agcr_job_t       mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            push, pop;

  assign full_o      = (cnt_q == CW'(QUEUE_DEPTH));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_job_o   = mem_q[rd_q];
  assign push        = push_valid_i && !full_o;
  assign pop         = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PW'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_job_i;
  end

endmodule

@@ rtl/core/agcr_back.sv @@
// ----------------------------------------------------------------------------
// agcr_back
// Sample history memory and serial multiply-accumulate over one filter phase.
// ----------------------------------------------------------------------------
module agcr_back import agcr_pkg::*; #(
  parameter int TAPS_PER_PHASE = 120
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  input  agcr_job_t                  job_i,
  output logic                       job_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] out_sample_o,
  output logic                       out_block_end_o
);

  localparam int AW    = (TAPS_PER_PHASE > 1) ? $clog2(TAPS_PER_PHASE) : 1;
  localparam int TW    = $clog2(TAPS_PER_PHASE + 1);
  localparam int PR_W  = SAMPLE_W + COEF_WIDTH;
  localparam int ACC_W = PR_W + TW;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_MAC  = 3'b010,
    B_DONE = 3'b100
  } bstate_e;

  bstate_e                    state_q;
  logic signed [SAMPLE_W-1:0] hist_mem [TAPS_PER_PHASE];
  logic [AW-1:0]              wp_q, rd_addr_q;
  logic [TW-1:0]              tap_q;
  logic [TW-1:0]              hcnt_q;
  logic [PHASE_W-1:0]         phase_q;
  logic                       bend_q;
  logic signed [SAMPLE_W-1:0] rd_data_q;
  logic                       rd_ok_q;
  coef_t                      coef_q;
  logic signed [PR_W-1:0]     prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic                       v1_q, v2_q;
  logic                       out_valid_q, out_bend_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;

  logic                       issuing, load;
  logic signed [SAMPLE_W-1:0] tap_smp;
  logic [ACC_W-1:0]           acc_mag, acc_sh;
  logic signed [SAMPLE_W-1:0] res;

  assign issuing   = (state_q == B_MAC) && (tap_q < TW'(TAPS_PER_PHASE));
  assign job_pop_o = (state_q == B_IDLE) && job_valid_i;
  assign load      = (state_q == B_DONE) && (!out_valid_q || !out_stall_i);

  // history is written in address order from zero; entries past the fill count read as zero
  assign tap_smp = rd_ok_q ? rd_data_q : '0;

  // Truncate toward zero, then saturate.
  assign acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign acc_sh  = acc_mag >> COEF_FRAC;
  always_comb begin
    if (acc_q[ACC_W-1]) begin
      res = (acc_sh > ACC_W'(32768)) ? -16'sd32768 : SAMPLE_W'(-acc_sh);
    end else begin
      res = (acc_sh > ACC_W'(32767)) ? 16'sd32767 : SAMPLE_W'(acc_sh);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_sample_o    = out_sample_q;
  assign out_block_end_o = out_bend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      wp_q        <= '0;
      hcnt_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= issuing;
      v2_q <= v1_q;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: if (job_valid_i) begin
          wp_q <= (wp_q == AW'(TAPS_PER_PHASE-1)) ? '0 : wp_q + 1'b1;
          if (hcnt_q != TW'(TAPS_PER_PHASE)) hcnt_q <= hcnt_q + 1'b1;
          if (job_i.due) state_q <= B_MAC;
        end
        B_MAC:  if (!issuing && !v1_q && !v2_q) state_q <= B_DONE;
        B_DONE: if (load) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= hist_mem[rd_addr_q];
    rd_ok_q   <= (TW'(rd_addr_q) < hcnt_q);
    if (job_pop_o) begin
      hist_mem[wp_q] <= job_i.sample;
      rd_addr_q      <= wp_q;
      tap_q          <= '0;
      phase_q        <= job_i.phase;
      bend_q         <= job_i.block_end;
      acc_q          <= '0;
    end else begin
      if (issuing) begin
        coef_q    <= coef_at(int'(phase_q), int'(tap_q));
        tap_q     <= tap_q + 1'b1;
        rd_addr_q <= (rd_addr_q == '0) ? AW'(TAPS_PER_PHASE-1) : rd_addr_q - 1'b1;
      end
      if (v1_q) prod_q <= PR_W'(tap_smp) * PR_W'(coef_q);
      if (v2_q) acc_q  <= acc_q + ACC_W'(prod_q);
    end
    if (load) begin
      out_sample_q <= res;
      out_bend_q   <= bend_q;
    end
  end

endmodule
